// ----- design/bra_pkg.sv -----
// Shared types and constants for the bitmap range allocator.
// Used by bitmap_range_allocator_core; no dependencies of its own.
`default_nettype none
package bra_pkg;

   localparam int MAP_BITS   = 1024;
   localparam int WORD_BITS  = 64;
   localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int IDX_W      = $clog2(MAP_BITS) + 1;

   localparam logic [2:0] OP_SET      = 3'd0;
   localparam logic [2:0] OP_CONTAINS = 3'd1;
   localparam logic [2:0] OP_ALL_SET  = 3'd2;
   localparam logic [2:0] OP_SCAN     = 3'd3;
   localparam logic [2:0] OP_FLIP     = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_LOAD,
      ST_BITS,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ----- design/bra_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module bra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ----- design/bitmap_range_allocator_core.sv -----
// Top level of the bitmap range allocator: request decode, word walk and response.
// Depends on bra_pkg and bra_ram.
//
//  channel | direction | contents
//  req_*   | in        | tuser: req_type; tdata: start_req, count, bit_value
//  rsp_*   | out       | tdata: status, answer, found, run_index
//  csr_*   | in        | bit_count write
//
// A transaction walks the bitmap one bit per cycle, pausing for a word load at each
// word boundary crossed; around the walk come decode, first fetch, first load,
// done and the idle state that takes the next request.
// Scan walks the bitmap once; flip then walks the found run again to invert it.
// After reset the bitmap reads as cleared at once (per-word valid flags).
// A finished result waits in the output register; a new request is taken
// meanwhile, and only the end of that next transaction waits for rsp_tready.
`default_nettype none
module bitmap_range_allocator_core
   import bra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [2:0]  req_tuser,   // [2:0] req_type
   input  wire logic [23:0] req_tdata,   // [10:0] start_req, [21:11] count, [22] bit_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [0] status, [1] answer, [2] found, [13:3] run_index
   input  wire logic        csr_we,
   input  wire logic [10:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [10:0]          bitcount_ff;
   logic [2:0]           op_ff;
   logic [IDX_W-1:0]     start_ff, cnt_ff;
   logic                 val_ff;
   logic [IDX_W-1:0]     idx_ff, idx_in, end_ff, end_in, run_ff, run_in;
   logic                 wmode_ff, wmode_in, wval_ff, wval_in;
   logic [WORD_BITS-1:0] word_ff, word_in, word_mod;
   logic                 rvalid_ff, rvalid_in;
   logic [WORD_COUNT-1:0] valid_ff;
   logic                 status_ff, status_in, answer_ff, answer_in, found_ff, found_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_data_ff, rsp_data_in;

   logic                 mem_we;
   logic [WADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_rdata;

   logic [IDX_W-1:0]     n_bits, idx_nx, run_nx, pos_cand;
   logic [IDX_W:0]       range_end;
   logic                 bit_cur, is_last, is_boundary, stop;
   logic [WADDR_W-1:0]   cur_word, nx_word;

   assign n_bits    = (bitcount_ff > 11'(MAP_BITS)) ? IDX_W'(MAP_BITS) : IDX_W'(bitcount_ff);
   assign range_end = {1'b0, start_ff} + {1'b0, cnt_ff};
   assign idx_nx    = idx_ff + 1'b1;
   assign run_nx    = run_ff + 1'b1;
   assign pos_cand  = idx_nx - cnt_ff;
   assign cur_word  = idx_ff[BIT_W+WADDR_W-1:BIT_W];
   assign nx_word   = idx_nx[BIT_W+WADDR_W-1:BIT_W];
   assign bit_cur   = word_ff[idx_ff[BIT_W-1:0]];
   assign is_last   = (idx_nx == end_ff);
   assign is_boundary = &idx_ff[BIT_W-1:0];

   always_comb begin
      word_mod = word_ff;
      word_mod[idx_ff[BIT_W-1:0]] = wval_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      run_in       = run_ff;
      wmode_in     = wmode_ff;
      wval_in      = wval_ff;
      word_in      = word_ff;
      rvalid_in    = rvalid_ff;
      status_in    = status_ff;
      answer_in    = answer_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_word;
      mem_raddr    = cur_word;
      stop         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            status_in = 1'b0;
            answer_in = 1'b0;
            found_in  = 1'b0;
            pos_in    = '0;
            run_in    = '0;
            wmode_in  = 1'b0;
            wval_in   = val_ff;
            idx_in    = start_ff;
            state_in  = ST_DONE;
            if (op_ff > OP_FLIP) begin
               status_in = 1'b1;
            end else if (op_ff <= OP_ALL_SET) begin
               if (range_end > {1'b0, n_bits}) begin
                  status_in = 1'b1;
               end else if (cnt_ff == '0) begin
                  answer_in = (op_ff == OP_ALL_SET);
               end else begin
                  end_in   = range_end[IDX_W-1:0];
                  wmode_in = (op_ff == OP_SET);
                  state_in = ST_FETCH;
               end
            end else begin
               if (start_ff > n_bits) begin
                  status_in = 1'b1;
               end else if (cnt_ff == '0) begin
                  found_in = 1'b1;
                  pos_in   = start_ff;
               end else if (cnt_ff <= n_bits && start_ff != n_bits) begin
                  end_in   = n_bits;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            rvalid_in = valid_ff[cur_word];
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            word_in  = rvalid_ff ? mem_rdata : '0;
            state_in = ST_BITS;
         end
         ST_BITS: begin
            idx_in = idx_nx;
            if (wmode_ff) begin
               word_in = word_mod;
               if (is_last || is_boundary) begin
                  mem_we = 1'b1;
               end
            end else if (op_ff == OP_CONTAINS) begin
               if (bit_cur == val_ff) begin
                  answer_in = 1'b1;
                  stop      = 1'b1;
               end
            end else if (op_ff == OP_ALL_SET) begin
               if (!bit_cur) begin
                  stop = 1'b1;
               end else if (is_last) begin
                  answer_in = 1'b1;
               end
            end else begin
               if (bit_cur == val_ff) begin
                  run_in = run_nx;
                  if (run_nx == cnt_ff) begin
                     found_in = 1'b1;
                     pos_in   = pos_cand;
                     stop     = 1'b1;
                     if (op_ff == OP_FLIP) begin
                        // Second pass writes the inverted value over the run.
                        wmode_in = 1'b1;
                        wval_in  = !val_ff;
                        idx_in   = pos_cand;
                        end_in   = pos_cand + cnt_ff;
                     end
                  end
               end else begin
                  run_in = '0;
               end
            end

            if (stop) begin
               state_in = (wmode_in && !wmode_ff) ? ST_FETCH : ST_DONE;
            end else if (is_last) begin
               state_in = ST_DONE;
            end else if (is_boundary) begin
               mem_raddr = nx_word;
               rvalid_in = valid_ff[nx_word];
               state_in  = ST_LOAD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, pos_ff, found_ff, answer_ff, status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   bra_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(WORD_COUNT)
   ) u_words (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(word_mod),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bitcount_ff  <= 11'(MAP_BITS);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            bitcount_ff <= csr_wdata;
         end
         if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser;
         start_ff <= req_tdata[10:0];
         cnt_ff   <= req_tdata[21:11];
         val_ff   <= req_tdata[22];
      end
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      run_ff      <= run_in;
      wmode_ff    <= wmode_in;
      wval_ff     <= wval_in;
      word_ff     <= word_in;
      rvalid_ff   <= rvalid_in;
      status_ff   <= status_in;
      answer_ff   <= answer_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_BITS) && wmode_ff)
      else $error("word memory written outside a write walk");

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_CHECK)
      else $error("accepted request not decoded");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BITS |-> idx_ff < end_ff)
      else $error("walk index past its end");

   a_resp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside completion");

endmodule
`default_nettype wire
